// ===== rtl/pfch_pkg.sv =====
package pfch_pkg;

  // Grid and table geometry
  localparam int GRID_X         = 16;
  localparam int GRID_Y         = 16;
  // must stay a power of two: the cell index wraps by masking
  localparam int CELLS_PER_ZONE = 256;

  localparam int ACC_DEPTH  = 4 * CELLS_PER_ZONE;
  localparam int ACC_AW     = $clog2(ACC_DEPTH);
  localparam int CELL_W     = (CELLS_PER_ZONE > 1) ? $clog2(CELLS_PER_ZONE) : 1;
  localparam int CX_W       = (GRID_X > 1) ? $clog2(GRID_X) : 1;
  localparam int CY_W       = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
  localparam int CELL_SUM_W = 12;

  // Field widths
  localparam int POS_W      = 24;
  localparam int WGT_W      = 32;
  localparam int ACC_W      = 40;
  localparam int ADDR_W     = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int HIT_W      = 8;

  // Q12.12 position times Q8.16 scale gives Q20.28
  localparam int PROD_W     = 2 * POS_W;
  localparam int FRAC_SHIFT = 28;
  localparam int RAW_W      = PROD_W - FRAC_SHIFT;
  localparam logic [PROD_W-1:0] HALF_CELL = PROD_W'(1) << (FRAC_SHIFT - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZONE1_BOTTOM = 3'd0,
    CFG_ZONE1_TOP    = 3'd1,
    CFG_ZONE3_BOTTOM = 3'd2,
    CFG_BOX_TOP      = 3'd3,
    CFG_SCALE_X      = 3'd4,
    CFG_SCALE_Y      = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REQ_EVENT = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef struct packed {
    req_t              req_type;
    logic              species;
    logic [POS_W-1:0]  height_now;
    logic [POS_W-1:0]  height_before;
    logic [POS_W-1:0]  entry_x;
    logic [POS_W-1:0]  entry_y;
    logic [ADDR_W-1:0] table_addr;
    logic [WGT_W-1:0]  weight_data;
    logic              last_of_step;
  } in_item_t;

  typedef struct packed {
    logic                    crossed;
    logic                    negative_step;
    logic                    zone_hit;
    logic [HIT_W-1:0]        cell_hit;
    logic                    clamped;
    logic                    saturated;
    logic signed [ACC_W-1:0] read_value;
    logic                    last_flag;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0] zone1_bottom;
    logic [POS_W-1:0] zone1_top;
    logic [POS_W-1:0] zone3_bottom;
    logic [POS_W-1:0] box_top;
    logic [POS_W-1:0] scale_x;
    logic [POS_W-1:0] scale_y;
    logic [POS_W-1:0] mid1;
    logic [POS_W-1:0] mid3;
  } cfg_t;

  typedef struct packed {
    logic load_prod;
    logic load_coord;
  } cell_ctl_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_idx;
    logic              clamped;
  } cell_info_t;

  typedef struct packed {
    logic              rd;
    logic              upd;
    logic              clr;
    logic              neg;
    logic [ACC_AW-1:0] addr;
    logic [WGT_W-1:0]  weight;
  } acc_cmd_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] rdata;
    logic                    sat;
  } acc_rsp_t;

endpackage

// ===== rtl/pfch_cfg.sv =====
module pfch_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pfch_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfch_pkg::POS_W-1:0]         cfg_data,
  output pfch_pkg::cfg_t                     cfg
);
  import pfch_pkg::*;

  cfg_t             cfg_r;
  logic [POS_W:0]   sum1;
  logic [POS_W:0]   sum3;

  assign sum1 = {1'b0, cfg_r.zone1_bottom} + {1'b0, cfg_r.zone1_top};
  assign sum3 = {1'b0, cfg_r.zone3_bottom} + {1'b0, cfg_r.box_top};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zone1_bottom <= '0;
      cfg_r.zone1_top    <= '0;
      cfg_r.zone3_bottom <= '0;
      cfg_r.box_top      <= {POS_W{1'b1}};
      cfg_r.scale_x      <= POS_W'(65536);
      cfg_r.scale_y      <= POS_W'(65536);
      cfg_r.mid1         <= '0;
      cfg_r.mid3         <= '0;
    end else begin
      // midplanes registered from bounds; write only while idle (not enforced)
      cfg_r.mid1 <= sum1[POS_W:1];
      cfg_r.mid3 <= sum3[POS_W:1];
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ZONE1_BOTTOM: cfg_r.zone1_bottom <= cfg_data;
          CFG_ZONE1_TOP:    cfg_r.zone1_top    <= cfg_data;
          CFG_ZONE3_BOTTOM: cfg_r.zone3_bottom <= cfg_data;
          CFG_BOX_TOP:      cfg_r.box_top      <= cfg_data;
          CFG_SCALE_X:      cfg_r.scale_x      <= cfg_data;
          CFG_SCALE_Y:      cfg_r.scale_y      <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/pfch_cell.sv =====
module pfch_cell (
  input  logic                         clk,
  input  pfch_pkg::cell_ctl_t          ctl,
  input  logic [pfch_pkg::POS_W-1:0]   entry_x,
  input  logic [pfch_pkg::POS_W-1:0]   entry_y,
  input  logic [pfch_pkg::POS_W-1:0]   scale_x,
  input  logic [pfch_pkg::POS_W-1:0]   scale_y,
  output pfch_pkg::cell_info_t         info
);
  import pfch_pkg::*;

  logic [PROD_W-1:0]     prod_x_r;
  logic [PROD_W-1:0]     prod_y_r;
  logic [PROD_W-1:0]     dx;
  logic [PROD_W-1:0]     dy;
  logic [RAW_W-1:0]      raw_x;
  logic [RAW_W-1:0]      raw_y;
  logic [CX_W-1:0]       cx_nxt;
  logic [CY_W-1:0]       cy_nxt;
  logic                  clx;
  logic                  cly;
  logic [CX_W-1:0]       cx_r;
  logic [CY_W-1:0]       cy_r;
  logic                  clamp_r;
  logic [CELL_SUM_W-1:0] cell_sum;

  // stage 1: fixed-point position times grid scale
  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      prod_x_r <= PROD_W'(entry_x) * PROD_W'(scale_x);
      prod_y_r <= PROD_W'(entry_y) * PROD_W'(scale_y);
    end
  end

  // stage 2: trunc(p - 0.5); anything in (-0.5, 0) lands on zero unclamped
  always_comb begin
    dx     = prod_x_r - HALF_CELL;
    dy     = prod_y_r - HALF_CELL;
    raw_x  = dx[PROD_W-1:FRAC_SHIFT];
    raw_y  = dy[PROD_W-1:FRAC_SHIFT];
    cx_nxt = '0;
    cy_nxt = '0;
    clx    = 1'b0;
    cly    = 1'b0;
    if (prod_x_r >= HALF_CELL) begin
      if (raw_x > RAW_W'(GRID_X - 1)) begin
        cx_nxt = CX_W'(GRID_X - 1);
        clx    = 1'b1;
      end else begin
        cx_nxt = raw_x[CX_W-1:0];
      end
    end
    if (prod_y_r >= HALF_CELL) begin
      if (raw_y > RAW_W'(GRID_Y - 1)) begin
        cy_nxt = CY_W'(GRID_Y - 1);
        cly    = 1'b1;
      end else begin
        cy_nxt = raw_y[CY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_coord) begin
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      clamp_r <= clx | cly;
    end
  end

  assign cell_sum      = CELL_SUM_W'(cx_r) + CELL_SUM_W'(GRID_X) * CELL_SUM_W'(cy_r);
  assign info.cell_idx = cell_sum[CELL_W-1:0];
  assign info.clamped  = clamp_r;

endmodule

// ===== rtl/pfch_acc.sv =====
module pfch_acc (
  input  logic                clk,
  input  logic                rst_n,
  input  pfch_pkg::acc_cmd_t  cmd,
  output pfch_pkg::acc_rsp_t  rsp
);
  import pfch_pkg::*;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic signed [ACC_W-1:0] mem [ACC_DEPTH];
  logic signed [ACC_W-1:0] rdata_r;
  logic [ACC_AW-1:0]       addr_r;
  logic signed [ACC_W:0]   wext;
  logic signed [ACC_W:0]   sum;
  logic                    sat;
  logic signed [ACC_W-1:0] sum_sat;
  logic [ACC_AW-1:0]       wr_addr;
  logic signed [ACC_W-1:0] wr_data;

  always_comb begin
    wext    = signed'({(ACC_W + 1 - WGT_W)'(0), cmd.weight});
    sum     = cmd.neg ? ({rdata_r[ACC_W-1], rdata_r} - wext)
                      : ({rdata_r[ACC_W-1], rdata_r} + wext);
    sat     = sum[ACC_W] != sum[ACC_W-1];
    sum_sat = sat ? (sum[ACC_W] ? ACC_MIN : ACC_MAX) : sum[ACC_W-1:0];
    // the update writes back to the entry fetched the cycle before
    wr_addr = cmd.clr ? cmd.addr : addr_r;
    wr_data = cmd.clr ? '0 : sum_sat;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata_r <= mem[cmd.addr];
      addr_r  <= cmd.addr;
    end
    if (cmd.clr || cmd.upd) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rsp.rdata = rdata_r;
  assign rsp.sat   = sat;

  a_clr_alone: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr && (cmd.rd || cmd.upd)))
    else $error("clear sweep overlaps an accumulator access");

  a_upd_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> $past(cmd.rd))
    else $error("accumulator update without fetch in the previous cycle");

endmodule

// ===== rtl/pore_flux_crossing_histogram.sv =====
// Sequence: a crossing event passes S_EVAL, S_COORD, S_FETCH, S_UPDATE and S_DONE
//   (S_EVAL, S_COORD, S_DONE without one); a read S_FETCH, S_UPDATE, S_DONE; a weight write
//   S_DONE; a clear S_CLEAR (one accumulator entry zeroed per cycle), then S_DONE.
// One item at a time; an event update is a read-modify-write (fetch, then write back).
// The output register frees the input side: a new item is taken while a result waits.
// Reset (synchronous, active low) restores the registers, then sweeps all 1024
//   accumulators to zero with in_ready low; pore weights are not cleared.
module pore_flux_crossing_histogram (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pfch_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pfch_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [pfch_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pfch_pkg::POS_W-1:0]        cfg_data
);
  import pfch_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EVAL   = 7'b0000010,
    S_COORD  = 7'b0000100,
    S_FETCH  = 7'b0001000,
    S_UPDATE = 7'b0010000,
    S_DONE   = 7'b0100000,
    S_CLEAR  = 7'b1000000
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  in_item_t          item_r;
  out_item_t         res_r;
  out_item_t         out_data_r;
  logic              out_valid_r;
  logic [ACC_AW-1:0] clr_cnt_r;
  logic              clr_reply_r;
  logic              hit_r;
  logic              neg_r;
  logic              zone_r;
  logic [WGT_W-1:0]  wdata_r;
  logic [WGT_W-1:0]  wmem [CELLS_PER_ZONE];

  cfg_t              cfg;
  cell_ctl_t         cell_ctl;
  cell_info_t        cell_info;
  acc_cmd_t          acc_cmd;
  acc_rsp_t          acc_rsp;

  logic              in_fire;
  logic              done_load;
  logic              clr_last;
  logic              z1_in;
  logic              z3_in;
  logic              up1;
  logic              dn1;
  logic              up3;
  logic              dn3;
  logic              rd_ok;
  logic [ACC_AW-1:0] acc_idx;

  pfch_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pfch_cell u_cell (
    .clk     (clk),
    .ctl     (cell_ctl),
    .entry_x (item_r.entry_x),
    .entry_y (item_r.entry_y),
    .scale_x (cfg.scale_x),
    .scale_y (cfg.scale_y),
    .info    (cell_info)
  );

  pfch_acc u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (acc_cmd),
    .rsp   (acc_rsp)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign done_load = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign clr_last  = (clr_cnt_r == ACC_AW'(ACC_DEPTH - 1));
  assign rd_ok     = int'(item_r.table_addr) < ACC_DEPTH;
  assign acc_idx   = ACC_AW'(int'({item_r.species, zone_r}) * CELLS_PER_ZONE
                             + int'(cell_info.cell_idx));

  // zone tests; the second zone is only looked at outside the first
  always_comb begin
    z1_in = (item_r.height_now >= cfg.zone1_bottom) && (item_r.height_now < cfg.zone1_top);
    z3_in = (item_r.height_before >= cfg.zone3_bottom)
            && (item_r.height_before <= cfg.box_top);
    up1   = (item_r.height_now >= cfg.mid1) && (item_r.height_before < cfg.mid1);
    dn1   = (item_r.height_now < cfg.mid1) && (item_r.height_before >= cfg.mid1);
    up3   = (item_r.height_now > cfg.zone3_bottom) && (item_r.height_now < cfg.mid3)
            && (item_r.height_before >= cfg.mid3);
    dn3   = (item_r.height_now >= cfg.mid3) && (item_r.height_before < cfg.mid3);
  end

  always_comb begin
    cell_ctl.load_prod  = (state_r == S_EVAL);
    cell_ctl.load_coord = (state_r == S_COORD);
  end

  always_comb begin
    acc_cmd = '0;
    if (state_r == S_CLEAR) begin
      acc_cmd.clr  = 1'b1;
      acc_cmd.addr = clr_cnt_r;
    end
    if (state_r == S_FETCH) begin
      acc_cmd.rd   = 1'b1;
      acc_cmd.addr = (item_r.req_type == REQ_READ) ? item_r.table_addr[ACC_AW-1:0] : acc_idx;
    end
    if ((state_r == S_UPDATE) && (item_r.req_type == REQ_EVENT)) begin
      acc_cmd.upd    = 1'b1;
      acc_cmd.neg    = neg_r;
      acc_cmd.weight = wdata_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_data.req_type)
            REQ_EVENT: state_nxt = S_EVAL;
            REQ_WRITE: state_nxt = S_DONE;
            REQ_READ:  state_nxt = S_FETCH;
            REQ_CLEAR: state_nxt = S_CLEAR;
          endcase
        end
      end
      S_EVAL:   state_nxt = S_COORD;
      S_COORD:  state_nxt = hit_r ? S_FETCH : S_DONE;
      S_FETCH:  state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_DONE;
      S_DONE:   state_nxt = done_load ? S_IDLE : S_DONE;
      S_CLEAR: begin
        if (clr_last) begin
          state_nxt = clr_reply_r ? S_DONE : S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire && (in_data.req_type == REQ_CLEAR)) begin
        clr_cnt_r   <= '0;
        clr_reply_r <= 1'b1;
      end else if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (done_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r          <= in_data;
      res_r           <= '0;
      res_r.last_flag <= in_data.last_of_step;
    end
    if (state_r == S_EVAL) begin
      hit_r  <= z1_in ? (up1 || dn1) : (z3_in && (up3 || dn3));
      neg_r  <= z1_in ? dn1 : dn3;
      zone_r <= !z1_in;
    end
    if (state_r == S_UPDATE) begin
      if (item_r.req_type == REQ_READ) begin
        res_r.read_value <= rd_ok ? acc_rsp.rdata : '0;
      end else begin
        res_r.crossed       <= 1'b1;
        res_r.negative_step <= neg_r;
        res_r.zone_hit      <= zone_r;
        res_r.cell_hit      <= HIT_W'(cell_info.cell_idx);
        res_r.clamped       <= cell_info.clamped;
        res_r.saturated     <= acc_rsp.sat;
      end
    end
    if (done_load) begin
      out_data_r <= res_r;
    end
  end

  // pore weight table: written on accept, read while the accumulator is fetched
  always_ff @(posedge clk) begin
    if (in_fire && (in_data.req_type == REQ_WRITE)
        && (int'(in_data.table_addr) < CELLS_PER_ZONE)) begin
      wmem[in_data.table_addr[CELL_W-1:0]] <= in_data.weight_data;
    end
    if (state_r == S_FETCH) begin
      wdata_r <= wmem[cell_info.cell_idx];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("item accepted while the previous one is still in flight");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_DONE))
    else $error("result presented outside the done state");

  a_cross_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.crossed) |-> (out_data.read_value == '0))
    else $error("crossing result carries a read value");

endmodule

// ===== tb/sv/pore_flux_crossing_histogram_tb.sv =====
module pore_flux_crossing_histogram_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfch_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam longint ACC_HI = 64'sd549755813887;
  localparam longint ACC_LO = -64'sd549755813888;
  localparam logic [PROD_W-1:0] HALF_Q28 = PROD_W'(1) << 27;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_ZONE1_BOTTOM;
  logic [POS_W-1:0] cfg_data = '0;

  pore_flux_crossing_histogram uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow of the block's registers and tables
  logic [POS_W-1:0] z1_bot = '0;
  logic [POS_W-1:0] z1_top = '0;
  logic [POS_W-1:0] z3_bot = '0;
  logic [POS_W-1:0] box_hi = 24'hFFFFFF;
  logic [POS_W-1:0] sx = 24'h010000;
  logic [POS_W-1:0] sy = 24'h010000;
  logic [WGT_W-1:0] pore_wt [CELLS_PER_ZONE];
  longint flux_acc [ACC_DEPTH];
  int unsigned last_acc_idx = 0;

  out_item_t awaited_results [$];
  bit quiet = 1'b0;
  int faults = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int n_items = 0, n_cross = 0, n_clip = 0, n_sat = 0, n_read = 0, n_clear = 0;
  int n_setups = 0;

  function automatic int unsigned grid_coord(input logic [POS_W-1:0] pos,
                                             input logic [POS_W-1:0] scale,
                                             input int grid, output bit clip);
    logic [PROD_W-1:0] p;
    logic [PROD_W-1:0] c;
    clip = 1'b0;
    p = PROD_W'(pos) * PROD_W'(scale);
    // between -0.5 and 0 truncates to column 0, not a clamp
    if (p < HALF_Q28) return 0;
    c = (p - HALF_Q28) >> 28;
    if (c > PROD_W'(grid - 1)) begin
      clip = 1'b1;
      return grid - 1;
    end
    return int'(c);
  endfunction

  function automatic out_item_t crossing_outcome(input in_item_t it);
    out_item_t r;
    logic [POS_W:0] s1, s3;
    logic [POS_W-1:0] mid1, mid3;
    bit hit, neg, clip_x, clip_y, zone;
    int unsigned cx, cy, cell_no, idx;
    longint w, sum;
    r = '0;
    r.last_flag = it.last_of_step;
    hit = 1'b0;
    neg = 1'b0;
    zone = 1'b0;
    case (it.req_type)
      REQ_WRITE: begin
        if (it.table_addr < CELLS_PER_ZONE) pore_wt[it.table_addr[CELL_W-1:0]] = it.weight_data;
      end
      REQ_READ: begin
        r.read_value = flux_acc[it.table_addr][ACC_W-1:0];
        n_read++;
      end
      REQ_CLEAR: begin
        foreach (flux_acc[i]) flux_acc[i] = 0;
        n_clear++;
      end
      default: begin
        s1 = {1'b0, z1_bot} + {1'b0, z1_top};
        s3 = {1'b0, z3_bot} + {1'b0, box_hi};
        mid1 = s1[POS_W:1];
        mid3 = s3[POS_W:1];
        if (it.height_now >= z1_bot && it.height_now < z1_top) begin
          if (it.height_now >= mid1 && it.height_before < mid1) begin
            hit = 1'b1;
          end else if (it.height_now < mid1 && it.height_before >= mid1) begin
            hit = 1'b1;
            neg = 1'b1;
          end
        end else if (it.height_before >= z3_bot && it.height_before <= box_hi) begin
          zone = 1'b1;
          if (it.height_now > z3_bot && it.height_now < mid3 && it.height_before >= mid3) begin
            hit = 1'b1;
          end else if (it.height_now >= mid3 && it.height_before < mid3) begin
            hit = 1'b1;
            neg = 1'b1;
          end
        end
        if (hit) begin
          cx = grid_coord(it.entry_x, sx, GRID_X, clip_x);
          cy = grid_coord(it.entry_y, sy, GRID_Y, clip_y);
          cell_no = (cx + GRID_X * cy) % CELLS_PER_ZONE;
          idx = it.species * 2 * CELLS_PER_ZONE + zone * CELLS_PER_ZONE + cell_no;
          w = pore_wt[cell_no];
          sum = neg ? flux_acc[idx] - w : flux_acc[idx] + w;
          if (sum > ACC_HI) begin
            sum = ACC_HI;
            r.saturated = 1'b1;
          end
          if (sum < ACC_LO) begin
            sum = ACC_LO;
            r.saturated = 1'b1;
          end
          flux_acc[idx] = sum;
          last_acc_idx = idx;
          r.crossed = 1'b1;
          r.negative_step = neg;
          r.zone_hit = zone;
          r.cell_hit = cell_no[HIT_W-1:0];
          r.clamped = clip_x | clip_y;
          n_cross++;
          n_clip += r.clamped;
          n_sat += r.saturated;
        end
      end
    endcase
    return r;
  endfunction

  function automatic in_item_t rand_fields();
    in_item_t it;
    it.req_type = req_t'($urandom_range(0, 3));
    it.species = 1'($urandom_range(0, 1));
    it.height_now = POS_W'($urandom);
    it.height_before = POS_W'($urandom);
    it.entry_x = POS_W'($urandom);
    it.entry_y = POS_W'($urandom);
    it.table_addr = ADDR_W'($urandom);
    it.weight_data = $urandom;
    it.last_of_step = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic in_item_t mk_event(input logic [POS_W-1:0] now, prev, x, y);
    in_item_t it;
    it = rand_fields();
    it.req_type = REQ_EVENT;
    it.height_now = now;
    it.height_before = prev;
    it.entry_x = x;
    it.entry_y = y;
    return it;
  endfunction

  function automatic in_item_t mk_op(input req_t req, input logic [ADDR_W-1:0] addr,
                                     input logic [WGT_W-1:0] data);
    in_item_t it;
    it = rand_fields();
    it.req_type = req;
    it.table_addr = addr;
    it.weight_data = data;
    return it;
  endfunction

  // heights clustered on the zone edges and midplane
  function automatic logic [POS_W-1:0] pick_height(input logic [POS_W-1:0] lo, hi);
    logic [POS_W-1:0] m;
    logic [POS_W:0] s;
    s = {1'b0, lo} + {1'b0, hi};
    m = s[POS_W:1];
    case ($urandom_range(0, 9))
      0: return lo - 1'b1;
      1: return lo;
      2: return lo + 1'b1;
      3: return m - 1'b1;
      4: return m;
      5: return m + 1'b1;
      6: return hi - 1'b1;
      7: return hi;
      8: return POS_W'($urandom_range(lo, hi));
      default: return POS_W'($urandom);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_entry();
    case ($urandom_range(0, 2))
      0: return POS_W'($urandom & 32'h00000FFF);
      1: return POS_W'($urandom & 32'h0000FFFF);
      default: return POS_W'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int r;
    logic [POS_W-1:0] lo, hi;
    r = $urandom_range(0, 99);
    it = rand_fields();
    if (r < 70) begin
      if ($urandom_range(0, 1)) begin
        lo = z1_bot;
        hi = z1_top;
      end else begin
        lo = z3_bot;
        hi = box_hi;
      end
      it = mk_event(pick_height(lo, hi), pick_height(lo, hi), pick_entry(), pick_entry());
    end else if (r < 78) begin
      it.req_type = REQ_EVENT;
    end else if (r < 88) begin
      it.req_type = REQ_WRITE;
      if ($urandom_range(0, 3) != 0) it.table_addr[ADDR_W-1:8] = '0;
    end else if (r < 98) begin
      it.req_type = REQ_READ;
      if (r[0]) it.table_addr = ADDR_W'(last_acc_idx);
    end else begin
      it.req_type = REQ_CLEAR;
    end
    return it;
  endfunction

  function automatic string fmt_result(input out_item_t o);
    return $sformatf({"crossed=%0d neg=%0d zone=%0d cell=%0d clamped=%0d sat=%0d",
                      " read=%0d last=%0d"},
                     o.crossed, o.negative_step, o.zone_hit, o.cell_hit, o.clamped,
                     o.saturated, o.read_value, o.last_flag);
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    awaited_results.push_back(crossing_outcome(it));
    n_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic cfg_put(input cfg_idx_t idx, input logic [POS_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      CFG_ZONE1_BOTTOM: z1_bot = v;
      CFG_ZONE1_TOP:    z1_top = v;
      CFG_ZONE3_BOTTOM: z3_bot = v;
      CFG_BOX_TOP:      box_hi = v;
      CFG_SCALE_X:      sx = v;
      CFG_SCALE_Y:      sy = v;
      default: ;
    endcase
  endtask

  task automatic apply_setup(input logic [POS_W-1:0] b1, t1, b3, top, scx, scy);
    drain();
    cfg_put(CFG_ZONE1_BOTTOM, b1);
    cfg_put(CFG_ZONE1_TOP, t1);
    cfg_put(CFG_ZONE3_BOTTOM, b3);
    cfg_put(CFG_BOX_TOP, top);
    cfg_put(CFG_SCALE_X, scx);
    cfg_put(CFG_SCALE_Y, scy);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_setups++;
  endtask

  task automatic random_batch(input int n);
    for (int k = 0; k < n; k++) begin
      if (k % 6 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_item(random_item());
    end
    quiet = 1'b0;
    drain();
  endtask

  // every weight gets written before any event can look one up
  task automatic test_weight_load();
    send_item(mk_op(REQ_WRITE, 0, 32'hFFFFFFFF));
    send_item(mk_op(REQ_WRITE, 1, 32'h00000000));
    for (int a = 2; a < CELLS_PER_ZONE; a++) send_item(mk_op(REQ_WRITE, ADDR_W'(a), $urandom));
    send_item(mk_op(REQ_WRITE, 10'd300, $urandom));
    send_item(mk_op(REQ_WRITE, 10'd1023, $urandom));
  endtask

  task automatic test_event_cases();
    apply_setup(24'h001000, 24'h003000, 24'h005000, 24'h007000, 24'h100000, 24'h100000);
    send_item(mk_op(REQ_WRITE, 55, 32'h00010000));
    send_item(mk_event(24'h002000, 24'h001FFF, 24'h000800, 24'h000400)); // up, zone one
    send_item(mk_op(REQ_READ, ADDR_W'(last_acc_idx), 0));
    send_item(mk_event(24'h001FFF, 24'h002000, 24'h001000, 24'h001000)); // down, zone one
    send_item(mk_event(24'h002800, 24'h002100, 24'h000800, 24'h000800)); // no crossing
    send_item(mk_event(24'h003000, 24'h002000, 24'h000800, 24'h000800)); // zone one top open
    send_item(mk_event(24'h005800, 24'h006000, 24'hFFFFFF, 24'hFFFFFF)); // up, zone two, clamp
    send_item(mk_event(24'h006000, 24'h005FFF, 24'h00007F, 24'h000080)); // down, half-cell edge
    send_item(mk_event(24'h005000, 24'h006800, 24'h000400, 24'h000400)); // now on zone2 bottom
    send_item(mk_event(24'h005001, 24'h007000, 24'h000400, 24'h000C00)); // box top inclusive
    send_item(mk_event(24'h001800, 24'h006800, 24'h000C00, 24'h000400)); // zone one wins
    send_item(mk_event(24'h000000, 24'hFFFFFF, 24'h000000, 24'h000000));
    send_item(mk_event(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000));
    send_item(mk_op(REQ_READ, ADDR_W'(last_acc_idx), 0));
    send_item(mk_op(REQ_READ, 0, 0));
    send_item(mk_op(REQ_READ, 10'd1023, 0));
    send_item(mk_op(REQ_CLEAR, 0, 0));
    send_item(mk_op(REQ_READ, ADDR_W'(last_acc_idx), 0));
  endtask

  task automatic test_saturation();
    in_item_t it;
    send_item(mk_op(REQ_WRITE, 0, 32'hFFFFFFFF));
    send_item(mk_op(REQ_CLEAR, 0, 0));
    for (int k = 0; k < 130; k++) begin
      it = mk_event(24'h002000, 24'h001FFF, 24'h000000, 24'h000000);
      it.species = 1'b0;
      send_item(it);
    end
    send_item(mk_op(REQ_READ, 0, 0));
    send_item(mk_op(REQ_CLEAR, 0, 0));
    for (int k = 0; k < 130; k++) begin
      it = mk_event(24'h001FFF, 24'h002000, 24'h000000, 24'h000000);
      it.species = 1'b1;
      send_item(it);
    end
    send_item(mk_op(REQ_READ, 10'd512, 0));
    send_item(mk_op(REQ_CLEAR, 0, 0));
  endtask

  task automatic test_setup_sweep();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apply_setup(24'h001000, 24'h003000, 24'h005000, 24'h007000, 24'h100000, 24'h100000);
        1: apply_setup(24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000);
        2: apply_setup(24'hFFFFFF, 24'hFFFFFF, 24'h800000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF);
        3: apply_setup(24'h000000, 24'h000000, 24'h000000, 24'hFFFFFF, 24'h010000, 24'h010000);
        4: apply_setup(24'h003000, 24'h001000, 24'h007000, 24'h005000, 24'h008000, 24'h200000);
        default: apply_setup(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                             POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
      endcase
      random_batch(18);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        faults++;
        if (faults <= 10) $display("unexpected result: %s", fmt_result(out_data));
      end else begin
        out_item_t want;
        want = awaited_results.pop_front();
        if (out_data.crossed !== want.crossed || out_data.negative_step !== want.negative_step ||
            out_data.zone_hit !== want.zone_hit || out_data.cell_hit !== want.cell_hit ||
            out_data.clamped !== want.clamped || out_data.saturated !== want.saturated ||
            out_data.read_value !== want.read_value || out_data.last_flag !== want.last_flag)
        begin
          faults++;
          if (faults <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected %s", fmt_result(want));
            $display("  actual   %s", fmt_result(out_data));
          end
        end
      end
      hold_left = quiet ? 0 : $urandom_range(0, 4);
      if (hold_left > 0) out_ready <= 1'b0;
    end else if (!out_ready) begin
      if (hold_left > 1) begin
        hold_left--;
      end else begin
        hold_left = 0;
        out_ready <= 1'b1;
      end
    end
  end

  // the reset sweep and a clear each keep the input closed while all accumulators are zeroed
  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_weight_load();
    test_event_cases();
    test_saturation();
    test_setup_sweep();
    drain();
    repeat (20) @(posedge clk);
    faults += awaited_results.size();
    $display("%0d items over %0d register settings: %0d crossings, %0d clamped, %0d saturated",
             n_items, n_setups, n_cross, n_clip, n_sat);
    $display("%0d accumulator reads, %0d clears, %0d faults", n_read, n_clear, faults);
    if (faults == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pfch_pkg.sv
rtl/pfch_cfg.sv
rtl/pfch_cell.sv
rtl/pfch_acc.sv
rtl/pore_flux_crossing_histogram.sv
tb/sv/pore_flux_crossing_histogram_tb.sv
